### hw/rtl/msm_pkg.sv
`timescale 1ns / 1ps

package msm_pkg;

  localparam int unsigned SAMPLE_W   = 32;
  localparam int unsigned ADDR_W     = 32;  // signed window address, exact
  localparam int unsigned COORD_W    = 13;  // signed neighbor index
  localparam int unsigned GRID_W     = 11;
  localparam int unsigned STRIDE_W   = 16;
  localparam int unsigned QIDX_W     = 10;
  localparam int unsigned MUL_A_W    = 11;
  localparam int unsigned MUL_P_W    = MUL_A_W + STRIDE_W + 1;
  localparam int unsigned CNT_OUT_W  = 6;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_NX  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_NY  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_NZ  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_Z = 3'd5;

  // item function codes
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic                       func;
    logic [15:0]                cell_address;
    logic                       cell_present;
    logic signed [SAMPLE_W-1:0] cell_sample;
    logic [QIDX_W-1:0]          query_x;
    logic [QIDX_W-1:0]          query_y;
    logic [QIDX_W-1:0]          query_z;
  } msm_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mean_value;
    logic [CNT_OUT_W-1:0]       sample_count;
    logic                       range_error;
  } msm_out_t;

  typedef struct packed {
    logic [GRID_W-1:0]   nx;
    logic [GRID_W-1:0]   ny;
    logic [GRID_W-1:0]   nz;
    logic [STRIDE_W-1:0] sx;
    logic [STRIDE_W-1:0] sy;
    logic [STRIDE_W-1:0] sz;
  } msm_cfg_t;

  // window walker status toward the sequencer
  typedef struct packed {
    logic rd_en;
    logic done;
    logic err;
  } msm_win_st_t;

endpackage

### hw/rtl/msm_store.sv
`timescale 1ns / 1ps

module msm_store #(
  parameter int unsigned STORE_DEPTH = 65536
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               wr_en_i,
  input  logic [$clog2(STORE_DEPTH)-1:0]     wr_addr_i,
  input  logic [msm_pkg::SAMPLE_W-1:0]       wr_sample_i,
  input  logic                               wr_present_i,
  input  logic                               rd_en_i,
  input  logic [$clog2(STORE_DEPTH)-1:0]     rd_addr_i,
  output logic [msm_pkg::SAMPLE_W-1:0]       rd_sample_o,
  output logic                               rd_present_o,
  output logic                               busy_o
);
  import msm_pkg::*;

  localparam int unsigned AW = $clog2(STORE_DEPTH);

  logic [SAMPLE_W-1:0] sample_mem  [STORE_DEPTH];
  logic                present_mem [STORE_DEPTH];

  logic          clr_active_q;
  logic [AW-1:0] clr_addr_q;
  logic [SAMPLE_W-1:0] rd_sample_q;
  logic          rd_present_q;

  // present marks swept to zero after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_addr_q   <= '0;
    end else if (clr_active_q) begin
      clr_addr_q <= clr_addr_q + AW'(1);
      if (clr_addr_q == AW'(STORE_DEPTH - 1)) begin
        clr_active_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_active_q) begin
      present_mem[clr_addr_q] <= 1'b0;
    end else if (wr_en_i) begin
      present_mem[wr_addr_i] <= wr_present_i;
    end
    if (wr_en_i) begin
      sample_mem[wr_addr_i] <= wr_sample_i;
    end
    if (rd_en_i) begin
      rd_sample_q  <= sample_mem[rd_addr_i];
      rd_present_q <= present_mem[rd_addr_i];
    end
  end

  assign rd_sample_o  = rd_sample_q;
  assign rd_present_o = rd_present_q;
  assign busy_o       = clr_active_q;

endmodule

### hw/rtl/msm_window.sv
`timescale 1ns / 1ps

module msm_window #(
  parameter int unsigned STORE_DEPTH = 65536,
  parameter int unsigned HALF_WIDTH  = 3
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  msm_pkg::msm_cfg_t                cfg_i,
  input  logic                             start_i,
  input  logic [msm_pkg::QIDX_W-1:0]       q_x_i,
  input  logic [msm_pkg::QIDX_W-1:0]       q_y_i,
  input  logic [msm_pkg::QIDX_W-1:0]       q_z_i,
  output msm_pkg::msm_win_st_t             st_o,
  output logic [$clog2(STORE_DEPTH)-1:0]   rd_addr_o
);
  import msm_pkg::*;

  localparam int unsigned AW = $clog2(STORE_DEPTH);
  localparam int unsigned NW = 2 * HALF_WIDTH + 1;
  localparam int unsigned IW = $clog2(NW + 1);

  localparam logic [2:0] W_IDLE = 3'd0;
  localparam logic [2:0] W_M0   = 3'd1;
  localparam logic [2:0] W_M1   = 3'd2;
  localparam logic [2:0] W_M2   = 3'd3;
  localparam logic [2:0] W_M3   = 3'd4;
  localparam logic [2:0] W_SCAN = 3'd5;

  logic [2:0]                st_q;
  logic                      done_q, err_q;
  logic [QIDX_W-1:0]         qx_q, qy_q, qz_q;
  logic signed [MUL_P_W-1:0] prod_q;
  logic [ADDR_W-1:0]         acc_q, row_q, cur_q;
  logic [IW-1:0]             dy_q, dz_q;

  // shared multiplier: one base term per cycle
  logic signed [MUL_A_W-1:0] mul_a;
  logic [STRIDE_W-1:0]       mul_b;
  logic signed [MUL_P_W-1:0] mul_p;

  always_comb begin
    case (st_q)
      W_M1: begin
        mul_a = MUL_A_W'({1'b0, qy_q}) - MUL_A_W'(HALF_WIDTH);
        mul_b = cfg_i.sy;
      end
      W_M2: begin
        mul_a = MUL_A_W'({1'b0, qz_q}) - MUL_A_W'(HALF_WIDTH);
        mul_b = cfg_i.sz;
      end
      default: begin
        mul_a = MUL_A_W'({1'b0, qx_q});
        mul_b = cfg_i.sx;
      end
    endcase
  end

  assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'($signed({1'b0, mul_b}));

  logic [ADDR_W-1:0] prod_ext;
  assign prod_ext = {{(ADDR_W - MUL_P_W){prod_q[MUL_P_W-1]}}, prod_q};

  // scan decisions for the current (dy, dz) position
  logic [COORD_W-1:0] yy, zz;
  logic y_lo, y_hi, z_lo, z_hi, addr_bad, last_dy, last_dz;
  logic step_row, step_col, finish, hit_err, rd_en;

  assign yy       = COORD_W'(qy_q) + COORD_W'(dy_q) - COORD_W'(HALF_WIDTH);
  assign zz       = COORD_W'(qz_q) + COORD_W'(dz_q) - COORD_W'(HALF_WIDTH);
  assign y_lo     = yy[COORD_W-1];
  assign z_lo     = zz[COORD_W-1];
  assign y_hi     = !y_lo && (yy >= COORD_W'(cfg_i.ny));
  assign z_hi     = !z_lo && (zz >= COORD_W'(cfg_i.nz));
  assign addr_bad = cur_q[ADDR_W-1] || (cur_q >= ADDR_W'(STORE_DEPTH));
  assign last_dy  = (dy_q == IW'(NW - 1));
  assign last_dz  = (dz_q == IW'(NW - 1));

  always_comb begin
    step_row = 1'b0;
    step_col = 1'b0;
    finish   = 1'b0;
    hit_err  = 1'b0;
    rd_en    = 1'b0;
    if (st_q == W_SCAN) begin
      if (y_lo) begin
        step_row = 1'b1;
      end else if (y_hi) begin
        finish = 1'b1;
      end else if (z_hi) begin
        step_row = 1'b1;
      end else if (z_lo) begin
        step_col = 1'b1;
      end else if (addr_bad) begin
        finish  = 1'b1;
        hit_err = 1'b1;
      end else begin
        rd_en    = 1'b1;
        step_col = 1'b1;
      end
      if (step_col && last_dz) begin
        step_col = 1'b0;
        step_row = 1'b1;
      end
      if (step_row && last_dy) begin
        step_row = 1'b0;
        finish   = 1'b1;
      end
    end
  end

  // shared adder: base accumulation, then row and column steps
  logic [ADDR_W-1:0] add_a, add_b, add_s;

  always_comb begin
    case (st_q)
      W_M1: begin
        add_a = '0;
        add_b = prod_ext;
      end
      W_M2, W_M3: begin
        add_a = acc_q;
        add_b = prod_ext;
      end
      default: begin
        add_a = step_row ? row_q : cur_q;
        add_b = step_row ? ADDR_W'(cfg_i.sy) : ADDR_W'(cfg_i.sz);
      end
    endcase
  end

  assign add_s = add_a + add_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= W_IDLE;
      done_q <= 1'b0;
      err_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (st_q)
        W_IDLE: begin
          if (start_i) begin
            if ({1'b0, q_x_i} >= cfg_i.nx) begin
              done_q <= 1'b1;
              err_q  <= 1'b0;
            end else begin
              st_q <= W_M0;
            end
          end
        end
        W_M0: st_q <= W_M1;
        W_M1: st_q <= W_M2;
        W_M2: st_q <= W_M3;
        W_M3: st_q <= W_SCAN;
        W_SCAN: begin
          if (finish) begin
            st_q   <= W_IDLE;
            done_q <= 1'b1;
            err_q  <= hit_err;
          end
        end
        default: st_q <= W_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == W_IDLE && start_i) begin
      qx_q <= q_x_i;
      qy_q <= q_y_i;
      qz_q <= q_z_i;
    end
    case (st_q)
      W_M0: prod_q <= mul_p;
      W_M1, W_M2: begin
        acc_q  <= add_s;
        prod_q <= mul_p;
      end
      W_M3: begin
        row_q <= add_s;
        cur_q <= add_s;
        dy_q  <= '0;
        dz_q  <= '0;
      end
      W_SCAN: begin
        if (step_row) begin
          row_q <= add_s;
          cur_q <= add_s;
          dy_q  <= dy_q + IW'(1);
          dz_q  <= '0;
        end else if (step_col) begin
          cur_q <= add_s;
          dz_q  <= dz_q + IW'(1);
        end
      end
      default: ;
    endcase
  end

  assign st_o.rd_en = rd_en;
  assign st_o.done  = done_q;
  assign st_o.err   = err_q;
  assign rd_addr_o  = cur_q[AW-1:0];

endmodule

### hw/rtl/msm_div.sv
`timescale 1ns / 1ps

module msm_div #(
  parameter int unsigned CW = 6
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    start_i,
  input  logic signed [msm_pkg::SAMPLE_W+CW-1:0]  dividend_i,
  input  logic [CW-1:0]                           divisor_i,
  output logic                                    done_o,
  output logic signed [msm_pkg::SAMPLE_W-1:0]     quotient_o
);
  import msm_pkg::*;

  localparam int unsigned SW   = SAMPLE_W + CW;
  localparam int unsigned CNTW = $clog2(SAMPLE_W + 1);

  logic            busy_q, done_q;
  logic [CNTW-1:0] cnt_q;
  logic [CW-1:0]   rem_q, div_q;
  logic [SAMPLE_W-1:0] low_q;
  logic            neg_q;

  logic [SW-1:0] mag;
  logic [CW:0]   trial, diff;
  logic          ge;

  assign mag   = dividend_i[SW-1] ? SW'(-dividend_i) : SW'(dividend_i);
  assign trial = {rem_q, low_q[SAMPLE_W-1]};
  assign ge    = (trial >= {1'b0, div_q});
  assign diff  = trial - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNTW'(SAMPLE_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNTW'(1);
        if (cnt_q == CNTW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // |sum| < count * 2^32, so the high part already sits below the divisor
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= mag[SW-1:SAMPLE_W];
      low_q <= mag[SAMPLE_W-1:0];
      div_q <= divisor_i;
      neg_q <= dividend_i[SW-1];
    end else if (busy_q) begin
      rem_q <= ge ? diff[CW-1:0] : trial[CW-1:0];
      low_q <= {low_q[SAMPLE_W-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? -low_q : low_q;

endmodule

### hw/rtl/masked_window_mean_smoother.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_ready_o    in_data_i  (msm_in_t)
// out      output     out_valid_o / out_ready_i  out_data_o (msm_out_t)
// cfg      input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// A load item is written to the store as it is accepted. For a query, the
// walker forms the base address on the shared multiplier (W_M0 to W_M3),
// scans the window on the single store read port (at most (2*HALF_WIDTH+1)^2
// positions; a skipped row counts as one), then the bit-serial divider runs
// its 32 steps plus done. An empty window or a range error skips the divider;
// a query with x off the grid skips the scan and gives an empty result. In is
// not ready while a query runs.
// After reset the present marks are swept clear, one entry a cycle, over the
// whole store; no item is accepted meanwhile, cfg writes are taken.
// A finished result sits in the output register; a new item may be taken
// while it waits, a query stalls at its end only if the previous result is
// still held.

module masked_window_mean_smoother #(
  parameter int unsigned STORE_DEPTH = 65536,
  parameter int unsigned HALF_WIDTH  = 3
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  msm_pkg::msm_in_t               in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output msm_pkg::msm_out_t              out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [msm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [msm_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import msm_pkg::*;

  localparam int unsigned AW = $clog2(STORE_DEPTH);
  localparam int unsigned NW = 2 * HALF_WIDTH + 1;
  localparam int unsigned CW = $clog2(NW * NW + 1);
  localparam int unsigned SW = SAMPLE_W + CW;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_FIN  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_PUT  = 3'd4;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  msm_cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.nx <= GRID_W'(1);
      cfg_q.ny <= GRID_W'(1);
      cfg_q.nz <= GRID_W'(1);
      cfg_q.sx <= STRIDE_W'(1);
      cfg_q.sy <= STRIDE_W'(1);
      cfg_q.sz <= STRIDE_W'(1);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_GRID_NX:  cfg_q.nx <= cfg_data_i[GRID_W-1:0];
        CFG_GRID_NY:  cfg_q.ny <= cfg_data_i[GRID_W-1:0];
        CFG_GRID_NZ:  cfg_q.nz <= cfg_data_i[GRID_W-1:0];
        CFG_STRIDE_X: cfg_q.sx <= cfg_data_i;
        CFG_STRIDE_Y: cfg_q.sy <= cfg_data_i;
        CFG_STRIDE_Z: cfg_q.sz <= cfg_data_i;
        default: ;  // unknown index: write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------
  logic [2:0]  state_q, state_d;
  logic        store_busy;
  logic        in_acc, win_start, load_wr;
  logic [ADDR_W-1:0] load_addr;

  assign in_ready_o = (state_q == S_IDLE) && !store_busy;
  assign in_acc     = in_valid_i && in_ready_o;
  assign load_addr  = ADDR_W'(in_data_i.cell_address);
  // loads past the end of the store are dropped
  assign load_wr    = in_acc && (in_data_i.func == FUNC_LOAD)
                      && (load_addr < ADDR_W'(STORE_DEPTH));
  assign win_start  = in_acc && (in_data_i.func == FUNC_QUERY);

  // ---------------------------------------------------------------------------
  // window address walker and store
  // ---------------------------------------------------------------------------
  msm_win_st_t          win_st;
  logic [AW-1:0]        win_addr;
  logic [SAMPLE_W-1:0]  rd_sample;
  logic                 rd_present;

  msm_window #(
    .STORE_DEPTH (STORE_DEPTH),
    .HALF_WIDTH  (HALF_WIDTH)
  ) u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .start_i   (win_start),
    .q_x_i     (in_data_i.query_x),
    .q_y_i     (in_data_i.query_y),
    .q_z_i     (in_data_i.query_z),
    .st_o      (win_st),
    .rd_addr_o (win_addr)
  );

  msm_store #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_en_i      (load_wr),
    .wr_addr_i    (load_addr[AW-1:0]),
    .wr_sample_i  (in_data_i.cell_sample),
    .wr_present_i (in_data_i.cell_present),
    .rd_en_i      (win_st.rd_en),
    .rd_addr_i    (win_addr),
    .rd_sample_o  (rd_sample),
    .rd_present_o (rd_present),
    .busy_o       (store_busy)
  );

  // ---------------------------------------------------------------------------
  // accumulate: read data lands in the cycle after the walker issues it
  // ---------------------------------------------------------------------------
  logic                 pend_q;
  logic signed [SW-1:0] sum_q;
  logic [CW-1:0]        count_q;
  logic                 err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= win_st.rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (win_start) begin
      sum_q   <= '0;
      count_q <= '0;
    end else if (pend_q && rd_present) begin
      sum_q   <= sum_q + {{CW{rd_sample[SAMPLE_W-1]}}, rd_sample};
      count_q <= count_q + CW'(1);
    end
    if (state_q == S_SCAN && win_st.done) begin
      err_q <= win_st.err;
    end
  end

  // ---------------------------------------------------------------------------
  // divide sum by count, truncating toward zero
  // ---------------------------------------------------------------------------
  logic                       div_start, div_done;
  logic signed [SAMPLE_W-1:0] div_q;
  logic                       no_div;

  assign no_div    = err_q || (count_q == '0);
  assign div_start = (state_q == S_FIN) && !no_div;

  msm_div #(
    .CW (CW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (count_q),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  logic out_valid_q;
  logic slot_free;
  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (win_start)      state_d = S_SCAN;
      S_SCAN: if (win_st.done)    state_d = S_FIN;
      S_FIN:  state_d = no_div ? S_PUT : S_DIV;
      S_DIV:  if (div_done)       state_d = S_PUT;
      S_PUT:  if (slot_free)      state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  msm_out_t out_q, res;

  // range error forces a zero mean and count
  always_comb begin
    res.range_error  = err_q;
    res.sample_count = err_q ? '0 : CNT_OUT_W'(count_q);
    res.mean_value   = no_div ? '0 : div_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_PUT && slot_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_PUT && slot_free) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_err_result_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PUT && slot_free && err_q) |=>
      (out_valid_o && out_data_o.range_error && out_data_o.mean_value == '0
       && out_data_o.sample_count == '0))
    else $error("range error result not cleared");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN) |-> (count_q <= CW'(NW * NW)))
    else $error("sample count exceeds window size");

  a_div_done_in_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished outside divide phase");

  a_read_in_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (win_st.rd_en || pend_q) |-> (state_q == S_SCAN))
    else $error("store read outside scan phase");

endmodule
